// ----- hw/rtl/bgr_to_hsl_pixel_macros.svh -----
// Assertion helpers shared by the bgr_to_hsl_pixel RTL.
// BHSL_ASSERT_NOW: consequent must hold in the same cycle as the antecedent.
// BHSL_ASSERT_NEXT: consequent must hold one cycle after the antecedent.
`ifndef BGR_TO_HSL_PIXEL_MACROS_SVH
`define BGR_TO_HSL_PIXEL_MACROS_SVH

`ifndef SYNTHESIS

`define BHSL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define BHSL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BHSL_ASSERT_NOW(label, clk, rstn, ante, cons)

`define BHSL_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- hw/rtl/bhsl_pkg.sv -----
package bhsl_pkg;

    // Which channel is the largest one
    typedef enum logic [1:0] {
        HUE_RED   = 2'd0,
        HUE_GREEN = 2'd1,
        HUE_BLUE  = 2'd2
    } hue_sel_t;

    localparam logic [7:0] HUE_OFF_RED   = 8'd0;
    localparam logic [7:0] HUE_OFF_GREEN = 8'd85;
    localparam logic [7:0] HUE_OFF_BLUE  = 8'd170;
    localparam logic [7:0] HUE_GREY      = 8'd170;
    localparam logic [7:0] SAT_GREY      = 8'd0;
    localparam logic [7:0] BYTE_MAX      = 8'd255;

    localparam logic [8:0] SUM_FLIP      = 9'd510;
    localparam logic [7:0] LIGHT_HALF    = 8'd127;
    localparam logic signed [14:0] HUE_SCALE = 15'sd42;

    // Reciprocal table: floor(RECIP_ONE / n), RECIP_SAT for n below 2
    localparam int unsigned RECIP_ONE   = 65536;
    localparam int unsigned RECIP_SAT   = 65535;
    localparam int unsigned RECIP_DEPTH = 256;

    // Stage 1: sorted channels
    typedef struct packed {
        logic [7:0]        mx;
        logic [7:0]        mn;
        logic signed [8:0] delta;
        hue_sel_t          sel;
    } sort_t;

    // Stage 2: lightness, folded sum, spread
    typedef struct packed {
        logic [7:0]        light;
        logic [7:0]        sum;
        logic [7:0]        diff;
        logic signed [8:0] delta;
        hue_sel_t          sel;
        logic              grey;
    } prep_t;

    // Stage 3: numerators and reciprocals
    typedef struct packed {
        logic [7:0]         light;
        logic               grey;
        hue_sel_t           sel;
        logic [15:0]        sat_num;
        logic signed [14:0] hue_num;
        logic [15:0]        sat_rcp;
        logic [15:0]        hue_rcp;
    } term_t;

    // Stage 4: products
    typedef struct packed {
        logic [7:0]         light;
        logic               grey;
        hue_sel_t           sel;
        logic [31:0]        sat_prod;
        logic signed [31:0] hue_prod;
    } prod_t;

    function automatic logic [7:0] hue_offset(hue_sel_t sel);
        logic [7:0] off;
        unique case (sel)
            HUE_RED:   off = HUE_OFF_RED;
            HUE_GREEN: off = HUE_OFF_GREEN;
            HUE_BLUE:  off = HUE_OFF_BLUE;
            default:   off = HUE_OFF_RED;
        endcase
        return off;
    endfunction

endpackage

// ----- hw/rtl/bhsl_sort.sv -----
`include "bgr_to_hsl_pixel_macros.svh"

module bhsl_sort (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      blue,
    input  logic [7:0]      green,
    input  logic [7:0]      red,
    output logic            out_valid,
    input  logic            out_ready,
    output bhsl_pkg::sort_t out_data
);

    logic            valid_reg;
    bhsl_pkg::sort_t data_reg;
    bhsl_pkg::sort_t data_next;
    logic            en;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // Pick largest, smallest and the hue numerator difference
    always_comb begin
        if (red > green) begin
            if (blue > red) begin
                data_next.mx    = blue;
                data_next.mn    = green;
                data_next.delta = $signed({1'b0, green}) - $signed({1'b0, red});
                data_next.sel   = bhsl_pkg::HUE_BLUE;
            end else begin
                data_next.mx    = red;
                data_next.mn    = (blue < green) ? blue : green;
                data_next.delta = $signed({1'b0, blue}) - $signed({1'b0, green});
                data_next.sel   = bhsl_pkg::HUE_RED;
            end
        end else begin
            if (blue > green) begin
                data_next.mx    = blue;
                data_next.mn    = red;
                data_next.delta = $signed({1'b0, green}) - $signed({1'b0, red});
                data_next.sel   = bhsl_pkg::HUE_BLUE;
            end else begin
                data_next.mx    = green;
                data_next.mn    = (blue < red) ? blue : red;
                data_next.delta = $signed({1'b0, red}) - $signed({1'b0, blue});
                data_next.sel   = bhsl_pkg::HUE_GREEN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `BHSL_ASSERT_NOW(a_sort_order, aclk, aresetn, valid_reg, data_reg.mx >= data_reg.mn)

endmodule

// ----- hw/rtl/bhsl_recip.sv -----
`include "bgr_to_hsl_pixel_macros.svh"

module bhsl_recip (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bhsl_pkg::sort_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output bhsl_pkg::term_t out_data
);

    // Reciprocal ROM, built at elaboration
    logic [15:0] recip_rom [bhsl_pkg::RECIP_DEPTH];

    for (genvar i = 0; i < bhsl_pkg::RECIP_DEPTH; i++) begin : g_rom
        localparam int unsigned RcpVal = (i < 2) ? bhsl_pkg::RECIP_SAT
                                                 : (bhsl_pkg::RECIP_ONE / i);
        assign recip_rom[i] = RcpVal[15:0];
    end

    logic            prep_valid_reg;
    bhsl_pkg::prep_t prep_reg;
    bhsl_pkg::prep_t prep_next;
    logic            term_valid_reg;
    bhsl_pkg::term_t term_reg;
    bhsl_pkg::term_t term_next;
    logic            prep_en;
    logic            term_en;

    logic [8:0]         mm_sum;
    logic [8:0]         mm_sum_rnd;
    logic [8:0]         sum_flip;
    logic signed [14:0] delta_ext;

    assign term_en  = !term_valid_reg || out_ready;
    assign prep_en  = !prep_valid_reg || term_en;
    assign in_ready = prep_en;

    // Stage A: lightness, folded sum, spread
    always_comb begin
        mm_sum              = {1'b0, in_data.mx} + {1'b0, in_data.mn};
        mm_sum_rnd          = mm_sum + 9'd1;
        sum_flip            = bhsl_pkg::SUM_FLIP - mm_sum;
        prep_next.light     = mm_sum_rnd[8:1];
        prep_next.sum       = (prep_next.light > bhsl_pkg::LIGHT_HALF) ? sum_flip[7:0]
                                                                        : mm_sum[7:0];
        prep_next.diff      = in_data.mx - in_data.mn;
        prep_next.delta     = in_data.delta;
        prep_next.sel       = in_data.sel;
        prep_next.grey      = (in_data.mx == in_data.mn);
    end

    // Stage B: rounded numerators and table lookups
    always_comb begin
        delta_ext          = {{6{prep_reg.delta[8]}}, prep_reg.delta};
        term_next.light    = prep_reg.light;
        term_next.grey     = prep_reg.grey;
        term_next.sel      = prep_reg.sel;
        term_next.sat_num  = {prep_reg.diff, 8'h00} - {8'h00, prep_reg.diff}
                           + {9'h000, prep_reg.sum[7:1]};
        term_next.hue_num  = delta_ext * bhsl_pkg::HUE_SCALE
                           + $signed({8'h00, prep_reg.diff[7:1]});
        term_next.sat_rcp  = recip_rom[prep_reg.sum];
        term_next.hue_rcp  = recip_rom[prep_reg.diff];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
            term_valid_reg <= 1'b0;
        end else begin
            if (prep_en) begin
                prep_valid_reg <= in_valid;
            end
            if (term_en) begin
                term_valid_reg <= prep_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prep_en) begin
            prep_reg <= prep_next;
        end
        if (term_en) begin
            term_reg <= term_next;
        end
    end

    assign out_valid = term_valid_reg;
    assign out_data  = term_reg;

    `BHSL_ASSERT_NOW(a_fold_nonzero, aclk, aresetn, prep_valid_reg && !prep_reg.grey, prep_reg.sum != 8'd0 && prep_reg.diff != 8'd0)
    `BHSL_ASSERT_NOW(a_sat_num_floor, aclk, aresetn, term_valid_reg && !term_reg.grey, term_reg.sat_num >= 16'd255)

endmodule

// ----- hw/rtl/bhsl_mult.sv -----
module bhsl_mult (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bhsl_pkg::term_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output bhsl_pkg::prod_t out_data
);

    logic            valid_reg;
    bhsl_pkg::prod_t data_reg;
    bhsl_pkg::prod_t data_next;
    logic            en;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // Two 16x16-class multipliers, one for saturation and one for hue
    always_comb begin
        data_next.light    = in_data.light;
        data_next.grey     = in_data.grey;
        data_next.sel      = in_data.sel;
        data_next.sat_prod = {16'h0000, in_data.sat_num} * {16'h0000, in_data.sat_rcp};
        data_next.hue_prod = {{17{in_data.hue_num[14]}}, in_data.hue_num}
                           * $signed({16'h0000, in_data.hue_rcp});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/bhsl_pack.sv -----
module bhsl_pack (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bhsl_pkg::prod_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      hue,
    output logic [7:0]      saturation,
    output logic [7:0]      lightness
);

    logic       valid_reg;
    logic [7:0] hue_reg;
    logic [7:0] hue_next;
    logic [7:0] sat_reg;
    logic [7:0] sat_next;
    logic [7:0] light_reg;
    logic       en;

    logic [15:0]        sat_sh;
    logic signed [15:0] hue_off;
    logic signed [16:0] hue_val;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // Scale down, apply offset, clamp to a byte; grey pixels get fixed hue and saturation
    always_comb begin
        sat_sh   = in_data.sat_prod[31:16];
        hue_off  = in_data.hue_prod[31:16];
        hue_val  = $signed({9'h000, bhsl_pkg::hue_offset(in_data.sel)})
                 - {hue_off[15], hue_off};
        if (in_data.grey) begin
            hue_next = bhsl_pkg::HUE_GREY;
            sat_next = bhsl_pkg::SAT_GREY;
        end else begin
            if (hue_val[16]) begin
                hue_next = 8'd0;
            end else if (|hue_val[15:8]) begin
                hue_next = bhsl_pkg::BYTE_MAX;
            end else begin
                hue_next = hue_val[7:0];
            end
            sat_next = (|sat_sh[15:8]) ? bhsl_pkg::BYTE_MAX : sat_sh[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            light_reg <= in_data.light;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = light_reg;

endmodule

// ----- hw/rtl/bgr_to_hsl_pixel.sv -----
// BGR to HSL pixel converter: takes one 8-bit blue/green/red pixel per transfer and returns
// 8-bit hue, saturation and lightness. It accepts a pixel every clock unless back-pressure fills
// the pipeline, and each passes five registered stages (sort, fold, reciprocal lookup, multiply,
// clamp). Each stage holds its data while stalled, and m_ready reaches s_ready combinationally
// through the five stages, so an output stall with every stage full stops the input in the same
// cycle without loss. Grey pixels give hue 170 and saturation 0; hue clamps to 0..255, no wrap.
`include "bgr_to_hsl_pixel_macros.svh"

module bgr_to_hsl_pixel (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_blue,
    input  logic [7:0] s_green,
    input  logic [7:0] s_red,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_hue,
    output logic [7:0] m_saturation,
    output logic [7:0] m_lightness
);

    logic            sort_valid;
    logic            sort_ready;
    bhsl_pkg::sort_t sort_data;
    logic            term_valid;
    logic            term_ready;
    bhsl_pkg::term_t term_data;
    logic            prod_valid;
    logic            prod_ready;
    bhsl_pkg::prod_t prod_data;

    // Stage 1: channel sort
    bhsl_sort u_sort (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .blue      (s_blue),
        .green     (s_green),
        .red       (s_red),
        .out_valid (sort_valid),
        .out_ready (sort_ready),
        .out_data  (sort_data)
    );

    // Stages 2-3: fold and reciprocal lookup
    bhsl_recip u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sort_valid),
        .in_ready  (sort_ready),
        .in_data   (sort_data),
        .out_valid (term_valid),
        .out_ready (term_ready),
        .out_data  (term_data)
    );

    // Stage 4: multiply
    bhsl_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (term_valid),
        .in_ready  (term_ready),
        .in_data   (term_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    // Stage 5: clamp and output register
    bhsl_pack u_pack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (prod_valid),
        .in_ready   (prod_ready),
        .in_data    (prod_data),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .hue        (m_hue),
        .saturation (m_saturation),
        .lightness  (m_lightness)
    );

    `BHSL_ASSERT_NOW(a_ready_chain, aclk, aresetn, m_ready, s_ready)

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] lightness;
    } hsl_t;

    // One directed pixel; has_hsl marks rows whose result is typed in
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       has_hsl;
        hsl_t       hsl;
    } pixel_row_t;

    localparam int NUM_ROWS       = 22;
    localparam int NUM_SEGMENTS   = 9;
    localparam int SEG_ITEMS      = 203;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED    = 50;

    // Idle and stall odds per random segment; the last one runs flat out
    localparam int SRC_IDLE_PCT   [NUM_SEGMENTS] = '{20, 0, 50, 10, 30, 0, 60, 15, 0};
    localparam int SINK_STALL_PCT [NUM_SEGMENTS] = '{20, 40, 0, 10, 50, 0, 30, 60, 0};

    localparam hsl_t NO_HSL = '0;

    // Directed pixels: greys, primaries, ties, clamp, reciprocal and lightness edges
    localparam pixel_row_t PIXEL_TABLE [NUM_ROWS] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, '{bhsl_pkg::HUE_GREY, bhsl_pkg::SAT_GREY, 8'd0}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{bhsl_pkg::HUE_GREY, bhsl_pkg::SAT_GREY, 8'd255}},
        '{8'd128, 8'd128, 8'd128, 1'b1, '{bhsl_pkg::HUE_GREY, bhsl_pkg::SAT_GREY, 8'd128}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{bhsl_pkg::HUE_OFF_RED, bhsl_pkg::BYTE_MAX, 8'd128}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{bhsl_pkg::HUE_OFF_GREEN, bhsl_pkg::BYTE_MAX, 8'd128}},
        '{8'd255, 8'd0,   8'd0,   1'b1, '{bhsl_pkg::HUE_OFF_BLUE, bhsl_pkg::BYTE_MAX, 8'd128}},
        '{8'd255, 8'd0,   8'd255, 1'b1, '{8'd0, bhsl_pkg::BYTE_MAX, 8'd128}},
        '{8'd0,   8'd255, 8'd255, 1'b0, NO_HSL},
        '{8'd255, 8'd255, 8'd0,   1'b0, NO_HSL},
        '{8'd200, 8'd10,  8'd250, 1'b0, NO_HSL},
        '{8'd10,  8'd200, 8'd250, 1'b0, NO_HSL},
        '{8'd100, 8'd220, 8'd30,  1'b0, NO_HSL},
        '{8'd240, 8'd30,  8'd90,  1'b0, NO_HSL},
        '{8'd240, 8'd90,  8'd30,  1'b0, NO_HSL},
        '{8'd1,   8'd0,   8'd0,   1'b0, NO_HSL},
        '{8'd255, 8'd254, 8'd254, 1'b0, NO_HSL},
        '{8'd0,   8'd127, 8'd127, 1'b0, NO_HSL},
        '{8'd100, 8'd54,  8'd200, 1'b0, NO_HSL},
        '{8'd100, 8'd56,  8'd200, 1'b0, NO_HSL},
        '{8'd0,   8'd0,   8'd1,   1'b0, NO_HSL},
        '{8'd180, 8'd20,  8'd180, 1'b0, NO_HSL},
        '{8'd180, 8'd180, 8'd20,  1'b0, NO_HSL}
    };

    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [7:0] s_blue       = '0;
    logic [7:0] s_green      = '0;
    logic [7:0] s_red        = '0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic [7:0] m_hue;
    logic [7:0] m_saturation;
    logic [7:0] m_lightness;

    // Travels with the payload so the checker sees the typed-in result of a row
    logic       s_row_has_hsl = 1'b0;
    hsl_t       s_row_hsl     = '0;

    hsl_t        hsl_expected [$];
    int          hsl_in_flight  = 0;
    int          error_count    = 0;
    int          results_seen   = 0;
    int          quiet_cycles   = 0;
    int          sink_stall_pct = 0;
    int          sink_gap       = 0;
    int          src_idle_pct   = 0;

    bgr_to_hsl_pixel dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_blue       (s_blue),
        .s_green      (s_green),
        .s_red        (s_red),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hue        (m_hue),
        .m_saturation (m_saturation),
        .m_lightness  (m_lightness)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Q16 reciprocal, saturated for 0 and 1
    function automatic longint recip_q16(int n);
        return (n < 2) ? longint'(bhsl_pkg::RECIP_SAT) : longint'(bhsl_pkg::RECIP_ONE) / n;
    endfunction

    function automatic logic [7:0] clamp_byte(longint v);
        if (v < 0) return '0;
        if (v > longint'(bhsl_pkg::BYTE_MAX)) return bhsl_pkg::BYTE_MAX;
        return 8'(v);
    endfunction

    // Expected hue, saturation and lightness of one pixel
    function automatic hsl_t predict_hsl(logic [7:0] blue, logic [7:0] green, logic [7:0] red);
        bhsl_pkg::hue_sel_t sel;
        int       top, bottom, delta, sum, diff, light;
        longint   offset, sat_full, hue_full;
        hsl_t     hsl;
        // dominant channel; ties favour green over red and blue, and red over blue
        if (red > green) begin
            if (blue > red) begin
                sel = bhsl_pkg::HUE_BLUE;
                top = int'(blue);
                bottom = int'(green);
                delta = int'(green) - int'(red);
            end else begin
                sel = bhsl_pkg::HUE_RED;
                top = int'(red);
                bottom = (blue < green) ? int'(blue) : int'(green);
                delta = int'(blue) - int'(green);
            end
        end else begin
            if (blue > green) begin
                sel = bhsl_pkg::HUE_BLUE;
                top = int'(blue);
                bottom = int'(red);
                delta = int'(green) - int'(red);
            end else begin
                sel = bhsl_pkg::HUE_GREEN;
                top = int'(green);
                bottom = (blue < red) ? int'(blue) : int'(red);
                delta = int'(red) - int'(blue);
            end
        end
        case (sel)
            bhsl_pkg::HUE_GREEN: offset = longint'(bhsl_pkg::HUE_OFF_GREEN);
            bhsl_pkg::HUE_BLUE:  offset = longint'(bhsl_pkg::HUE_OFF_BLUE);
            default:             offset = longint'(bhsl_pkg::HUE_OFF_RED);
        endcase

        light = (top + bottom + 1) >> 1;
        hsl.lightness = clamp_byte(longint'(light));
        if (top == bottom) begin
            hsl.hue = bhsl_pkg::HUE_GREY;
            hsl.saturation = bhsl_pkg::SAT_GREY;
        end else begin
            sum = top + bottom;
            diff = top - bottom;
            // fold the upper half so the reciprocal index stays within a byte
            if (light > int'(bhsl_pkg::LIGHT_HALF)) begin
                sum = int'(bhsl_pkg::SUM_FLIP) - sum;
            end
            sat_full = (longint'(diff) * 255 + longint'(sum >> 1)) * recip_q16(sum);
            hue_full = (longint'(delta) * 42 + longint'(diff >> 1)) * recip_q16(diff);
            hsl.saturation = clamp_byte(sat_full >>> 16);
            hsl.hue = clamp_byte(offset - (hue_full >>> 16));
        end
        return hsl;
    endfunction

    // Random pixel {blue, green, red}, weighted toward the corners of the math
    function automatic logic [23:0] random_pixel();
        int unsigned kind, hi, lo, mid, perm;
        logic [7:0]  b, g, r;
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
            return 24'($urandom);
        end
        if (kind < 58) begin
            // grey
            lo = $urandom_range(0, 255);
            hi = lo;
            mid = lo;
        end else if (kind < 73) begin
            // nearly grey: tiny spread
            lo = $urandom_range(0, 250);
            hi = lo + $urandom_range(1, 5);
            mid = $urandom_range(lo, hi);
        end else if (kind < 85) begin
            // full-scale channels
            hi = 255;
            lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0;
            case ($urandom_range(0, 2))
                0:       mid = lo;
                1:       mid = hi;
                default: mid = $urandom_range(lo, hi);
            endcase
        end else if (kind < 95) begin
            // two channels tied
            hi = $urandom_range(1, 255);
            lo = $urandom_range(0, hi - 1);
            mid = $urandom_range(0, 1) ? hi : lo;
        end else begin
            // max + min around 255, where the lightness folds
            hi = $urandom_range(128, 254);
            lo = 254 - hi + $urandom_range(0, 2);
            mid = $urandom_range(lo, hi);
        end
        perm = $urandom_range(0, 5);
        case (perm)
            0:       begin b = 8'(hi);  g = 8'(mid); r = 8'(lo);  end
            1:       begin b = 8'(hi);  g = 8'(lo);  r = 8'(mid); end
            2:       begin b = 8'(mid); g = 8'(hi);  r = 8'(lo);  end
            3:       begin b = 8'(mid); g = 8'(lo);  r = 8'(hi);  end
            4:       begin b = 8'(lo);  g = 8'(hi);  r = 8'(mid); end
            default: begin b = 8'(lo);  g = 8'(mid); r = 8'(hi);  end
        endcase
        return {b, g, r};
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    // Present one pixel, after an optional idle burst, and hold it until transferred
    task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                              input logic [7:0] red, input logic has_hsl, input hsl_t hsl);
        int unsigned gap;
        gap = 0;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 5);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_blue        <= blue;
        s_green       <= green;
        s_red         <= red;
        s_row_has_hsl <= has_hsl;
        s_row_hsl     <= hsl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Hold off the sender until every pending result has come back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (hsl_in_flight != 0);
    endtask

    // Stimulus: reset, directed table, then random segments
    initial begin : stimulus
        logic [23:0] pix;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 25;
        sink_stall_pct <= 25;
        for (int i = 0; i < NUM_ROWS; i++) begin
            send_pixel(PIXEL_TABLE[i].blue, PIXEL_TABLE[i].green, PIXEL_TABLE[i].red,
                       PIXEL_TABLE[i].has_hsl, PIXEL_TABLE[i].hsl);
        end
        wait_results_drained();

        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            src_idle_pct = SRC_IDLE_PCT[seg];
            sink_stall_pct <= SINK_STALL_PCT[seg];
            for (int i = 0; i < SEG_ITEMS; i++) begin
                pix = random_pixel();
                send_pixel(pix[23:16], pix[15:8], pix[7:0], 1'b0, NO_HSL);
            end
            if (seg == 2 || seg == 6) begin
                wait_results_drained();
            end
        end

        // wind down: all results back, then an idle drain before the verdict
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("bgr_to_hsl_pixel verification clean");
        end else begin
            $display("bgr_to_hsl_pixel verification failed");
        end
        $finish;
    end

    // Result side backpressure: random stall bursts
    always @(posedge aclk) begin
        if (sink_gap != 0) begin
            m_ready  <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
            m_ready  <= 1'b0;
            sink_gap <= $urandom_range(0, 4);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Scoreboard: queue expectations on input transfers, check on output transfers
    always @(posedge aclk) begin : result_check
        hsl_t want;
        if (aresetn && s_valid && s_ready) begin
            hsl_expected.push_back(s_row_has_hsl ? s_row_hsl
                                                 : predict_hsl(s_blue, s_green, s_red));
        end
        if (aresetn && m_valid && m_ready) begin
            if (hsl_expected.size() == 0) begin
                report_error($sformatf("result %0d with nothing pending", results_seen));
            end else begin
                want = hsl_expected.pop_front();
                if (m_hue !== want.hue) begin
                    report_error($sformatf("result %0d hue %0d, want %0d",
                                           results_seen, m_hue, want.hue));
                end
                if (m_saturation !== want.saturation) begin
                    report_error($sformatf("result %0d saturation %0d, want %0d",
                                           results_seen, m_saturation, want.saturation));
                end
                if (m_lightness !== want.lightness) begin
                    report_error($sformatf("result %0d lightness %0d, want %0d",
                                           results_seen, m_lightness, want.lightness));
                end
            end
            results_seen++;
        end
        hsl_in_flight <= hsl_expected.size();
    end

    // Watchdog: too long without any transfer means the block hung
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR @%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
            $display("bgr_to_hsl_pixel verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/bhsl_pkg.sv
hw/rtl/bhsl_sort.sv
hw/rtl/bhsl_recip.sv
hw/rtl/bhsl_mult.sv
hw/rtl/bhsl_pack.sv
hw/rtl/bgr_to_hsl_pixel.sv
bench/testbench.sv
